[rtl/sfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types, constants and helpers for the single-precision adder.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned SigW  = 24;
  localparam int unsigned StatW = 2;
  localparam int unsigned DepthDefault = 4;

  localparam logic [WordW-1:0] ExpMask  = 32'h7F80_0000;
  localparam logic [WordW-1:0] SignMask = 32'h8000_0000;
  localparam logic [WordW-1:0] FracMask = 32'h007F_FFFF;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Stage 1 -> stage 2: operands ordered, small significand aligned.
  typedef struct packed {
    logic            bypass;
    logic [WordW-1:0] bypass_val;
    logic            sign;
    logic            sub;
    logic [ExpW-1:0] exp;
    logic [SigW-1:0] big_m;
    logic [SigW-1:0] small_m;
  } align_t;

  // Stage 2 -> stage 3: raw sum with leading-zero count.
  typedef struct packed {
    logic            bypass;
    logic [WordW-1:0] bypass_val;
    logic            sign;
    logic            zero;
    logic [ExpW:0]   exp;     // exponent after right renormalization
    logic [SigW-1:0] m;
    logic [4:0]      lz;
  } sum_t;

  typedef struct packed {
    logic [WordW-1:0] sum_bits;
    logic [StatW-1:0] status;
  } result_t;

  // Leading-zero count of a 24-bit value whose value is non-zero.
  function automatic logic [4:0] lzc24(input logic [SigW-1:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd0;
    found = 1'b0;
    for (int i = SigW - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 5'(SigW - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

[rtl/sfa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface sfa_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/sfa_align.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_align
// Unpack, pick the larger operand and align the smaller significand.
// ----------------------------------------------------------------------------
module sfa_align (
  input  logic                      a_zero,
  input  logic [sfa_pkg::WordW-1:0] operand_a,
  input  logic [sfa_pkg::WordW-1:0] operand_b,
  output sfa_pkg::align_t           al
);
  import sfa_pkg::*;

  logic [ExpW-1:0] ea, eb, d;
  logic [SigW-1:0] ma, mb, sm;
  logic            a_big;

  always_comb begin
    ea = operand_a[30:23];
    eb = operand_b[30:23];
    ma = {1'b1, operand_a[22:0]};
    mb = {1'b1, operand_b[22:0]};
    a_big = (ea > eb) || (ea == eb && ma >= mb);
    d  = a_big ? ea - eb : eb - ea;
    sm = a_big ? mb : ma;
    al.bypass     = a_zero || (eb == '0);
    al.bypass_val = a_zero ? operand_b : operand_a;
    al.sign       = a_big ? operand_a[31] : operand_b[31];
    al.sub        = operand_a[31] ^ operand_b[31];
    al.exp        = a_big ? ea : eb;
    al.big_m      = a_big ? ma : mb;
    al.small_m    = (d >= ExpW'(25)) ? '0 : (sm >> d);
  end
endmodule

[rtl/sfa_addsub.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_addsub
// Add or subtract aligned significands; count leading zeros.
// ----------------------------------------------------------------------------
module sfa_addsub (
  input  sfa_pkg::align_t al,
  output sfa_pkg::sum_t   sm
);
  import sfa_pkg::*;

  logic [SigW:0] raw;

  always_comb begin
    raw = al.sub ? {1'b0, al.big_m} - {1'b0, al.small_m}
                 : {1'b0, al.big_m} + {1'b0, al.small_m};
    sm.bypass     = al.bypass;
    sm.bypass_val = al.bypass_val;
    sm.sign       = al.sign;
    sm.zero       = (raw == '0);
    if (raw[SigW]) begin
      sm.m   = raw[SigW:1];
      sm.exp = {1'b0, al.exp} + 9'd1;
    end else begin
      sm.m   = raw[SigW-1:0];
      sm.exp = {1'b0, al.exp};
    end
    sm.lz = sm.zero ? 5'd0 : lzc24(sm.m);
  end
endmodule

[rtl/sfa_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_norm
// Left renormalize, range check and pack the result word.
// ----------------------------------------------------------------------------
module sfa_norm (
  input  sfa_pkg::sum_t    sm,
  output sfa_pkg::result_t res
);
  import sfa_pkg::*;

  logic [SigW-1:0] m;
  logic signed [ExpW+1:0] e;

  always_comb begin
    m = sm.m << sm.lz;
    e = $signed({1'b0, sm.exp}) - $signed({5'd0, sm.lz});
    if (sm.bypass) begin
      res.sum_bits = sm.bypass_val;
      res.status   = ST_OK;
    end else if (sm.zero) begin
      res.sum_bits = '0;
      res.status   = ST_OK;
    end else if (e >= 10'sd255) begin
      res.sum_bits = {sm.sign, 31'h7F80_0000};
      res.status   = ST_OVERFLOW;
    end else if (e <= 10'sd0) begin
      res.sum_bits = {sm.sign, 31'd0};
      res.status   = ST_UNDERFLOW;
    end else begin
      res.sum_bits = {sm.sign, e[ExpW-1:0], m[22:0]};
      res.status   = ST_OK;
    end
  end
endmodule

[rtl/single_float_adder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_float_adder
// Truncating IEEE single-precision adder, pipelined.
// ----------------------------------------------------------------------------
// Accepts one operand pair per cycle while the output is not stalled and
// offers each sum on the output from the last register stage. The four
// register stages are: input capture, alignment (ordering and barrel shift),
// add/subtract with leading-zero count, and renormalize/pack. Throughput is
// one item per clock when the output is not stalled. The pipeline is a chain
// of valid bits, each stage with its own advance: when the last stage holds a
// result that is not taken, it and the occupied stages directly behind it
// hold, and stages behind an empty stage still advance (bubbles collapse).
// Operands with a zero exponent field pass the other operand through; the
// result is never rounded. status: 0 ok, 1 overflow, 2 underflow.
// ----------------------------------------------------------------------------
module single_float_adder (
  input logic clk,
  input logic rst,
  sfa_if.sink   in_ch,
  sfa_if.source out_ch
);
  import sfa_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } opnd_t;

  opnd_t   s0;
  align_t  s1, al_next;
  sum_t    s2, sm_next;
  result_t s3, res_next;
  logic    v0, v1, v2, v3;
  logic    en0, en1, en2, en3;

  // Each stage advances when the next one is free or moving.
  assign en3 = !v3 || out_ch.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign in_ch.ready = en0;

  sfa_align u_align (
    .a_zero   (s0.a[30:23] == '0),
    .operand_a(s0.a),
    .operand_b(s0.b),
    .al       (al_next)
  );
  sfa_addsub u_addsub (.al(s1), .sm(sm_next));
  sfa_norm   u_norm   (.sm(s2), .res(res_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) v0 <= in_ch.valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Payload: capture on advance, no reset needed.
  always_ff @(posedge clk) begin
    if (en0) s0 <= in_ch.data;
    if (en1) s1 <= al_next;
    if (en2) s2 <= sm_next;
    if (en3) s3 <= res_next;
  end

  assign out_ch.valid = v3;
  assign out_ch.data  = s3;
endmodule

[rtl/sfa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_checker
// Port-level checks on the adder's output channel.
// ----------------------------------------------------------------------------
module sfa_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sfa_pkg::WordW-1:0] out_sum,
  input logic [sfa_pkg::StatW-1:0] out_status
);
  import sfa_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sum) && $stable(out_status))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_overflow_inf: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_OVERFLOW |-> out_sum[30:0] == 31'h7F80_0000)
    else $error("overflow without infinity");

  a_underflow_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_UNDERFLOW |-> out_sum[30:0] == 31'd0)
    else $error("underflow without zero");
endmodule

bind single_float_adder sfa_checker u_sfa_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_sum   (out_ch.data.sum_bits),
  .out_status(out_ch.data.status)
);
